FILE: src/imtp_pkg.sv
// Shared types, character codes and helper functions of the inline markup text parser.
// Has no dependencies; every other file but imtp_fifo refers to it by scoped names.

package imtp_pkg;

  // Character codes that the parser recognizes.
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_L       = 8'h6C;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Style bit positions and their masks.
  localparam int UNDERLINE_BIT = 0;
  localparam int BOLD_BIT      = 1;
  localparam int STRIKE_BIT    = 2;
  localparam logic [7:0] MASK_UNDERLINE = 8'(1) << UNDERLINE_BIT;
  localparam logic [7:0] MASK_BOLD      = 8'(1) << BOLD_BIT;
  localparam logic [7:0] MASK_STRIKE    = 8'(1) << STRIKE_BIT;

  // Number of argument characters of the colour and code page tags, minus one.
  localparam logic [2:0] COLOR_LAST_DIGIT = 3'd7;
  localparam logic [2:0] PAGE_LAST_DIGIT  = 3'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STYLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PAGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_PAGE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKUP_EN     = 3'd4;
  localparam int CFG_DATA_W = 32;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_TEXT  = 3'd1,
    MODE_HASH  = 3'd2,
    MODE_COLOR = 3'd3,
    MODE_PAGE  = 3'd4,
    MODE_NEG   = 3'd5
  } mode_t;

  // Input beat.
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [7:0]  out_char;
    logic [31:0] out_color;
    logic [7:0]  out_style;
    logic [15:0] out_code_page;
    logic        has_char;
    logic        out_last;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [31:0] default_color;
    logic [7:0]  default_style;
    logic [15:0] default_code_page;
    logic [15:0] global_code_page;
    logic        markup_enable;
  } cfg_t;

  // Character class flags, worked out by the front end.
  typedef struct packed {
    logic is_hash;
    logic is_bslash;
    logic is_c;
    logic is_l;
    logic is_n;
    logic is_u;
    logic is_b;
    logic is_s;
  } cls_t;

  // Classified byte passed from front end to back end.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [7:0] nib;
    cls_t       cls;
  } op_t;

  // Lax hex nibble: bytes 97 to 127 map by b - 87, anything else by b - 48 mod 256.
  function automatic logic [7:0] nibble_of(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'd97 && b <= 8'd127) begin
      v = b - 8'd87;
    end else begin
      v = b + 8'd208;
    end
    return v;
  endfunction

  // Code page from four characters read like atoi; zero gives the global page.
  function automatic logic [15:0] parse_page(input logic [31:0] d,
                                             input logic [15:0] gcp);
    logic [7:0]  c;
    logic [13:0] val;
    logic        neg;
    logic [1:0]  phase;
    logic [15:0] res;
    val   = '0;
    neg   = 1'b0;
    phase = 2'd0;
    for (int i = 0; i < 4; i++) begin
      c = d[8*i +: 8];
      case (phase)
        2'd0: begin
          // Leading white space, then an optional sign or the first digit.
          if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
            phase = 2'd0;
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            neg   = (c == CH_MINUS);
            phase = 2'd1;
          end else if (c >= 8'h30 && c <= 8'h39) begin
            val   = {10'd0, c[3:0]};
            phase = 2'd1;
          end else begin
            phase = 2'd2;
          end
        end
        2'd1: begin
          if (c >= 8'h30 && c <= 8'h39) begin
            val = (val << 3) + (val << 1) + {10'd0, c[3:0]};
          end else begin
            phase = 2'd2;
          end
        end
        default: begin
          phase = 2'd2;
        end
      endcase
    end
    if (val == '0) begin
      res = gcp;
    end else if (neg) begin
      res = 16'd0 - {2'd0, val};
    end else begin
      res = {2'd0, val};
    end
    return res;
  endfunction

endpackage

FILE: src/imtp_fifo.sv
// Small first-in first-out queue of register entries, generic in its entry type.
// Has no package dependencies; serves as the beat and result queues of the parser.

module imtp_fifo #(
  parameter type T     = logic [7:0],
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wr_data,
  output logic full,
  input  logic pop,
  output T     rd_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  T              mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: src/imtp_front.sv
// Front end of the markup parser: classifies each input byte for the back end.
// Depends on imtp_pkg for the beat, class and character code definitions.

module imtp_front (
  input  imtp_pkg::in_item_t item_i,
  output imtp_pkg::op_t      op_o
);

  imtp_pkg::cls_t cls;

  // Character class flags.
  always_comb begin
    cls.is_hash   = (item_i.in_char == imtp_pkg::CH_HASH);
    cls.is_bslash = (item_i.in_char == imtp_pkg::CH_BSLASH);
    cls.is_c      = (item_i.in_char == imtp_pkg::CH_C);
    cls.is_l      = (item_i.in_char == imtp_pkg::CH_L);
    cls.is_n      = (item_i.in_char == imtp_pkg::CH_N);
    cls.is_u      = (item_i.in_char == imtp_pkg::CH_U);
    cls.is_b      = (item_i.in_char == imtp_pkg::CH_B);
    cls.is_s      = (item_i.in_char == imtp_pkg::CH_S);
  end

  // Classified beat, with the colour nibble worked out ahead of time.
  always_comb begin
    op_o.ch   = item_i.in_char;
    op_o.last = item_i.in_last;
    op_o.nib  = imtp_pkg::nibble_of(item_i.in_char);
    op_o.cls  = cls;
  end

endmodule

FILE: src/imtp_back.sv
// Back end of the markup parser: runs the tag state machine on classified beats
// and pushes result beats into the output queue. Depends on imtp_pkg.

module imtp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  imtp_pkg::cfg_t      cfg_i,
  input  imtp_pkg::op_t       op_i,
  input  logic                op_empty_i,
  output logic                op_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output imtp_pkg::out_item_t res_o
);

  imtp_pkg::mode_t mode_r, mode_nxt, e_mode;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [31:0]     acc_r, acc_nxt, acc_new;
  logic [7:0]      pdig_r [4];
  logic            pend_r, pend_nxt, e_pend;
  logic [31:0]     color_r, color_nxt, e_color;
  logic [7:0]      style_r, style_nxt, e_style;
  logic [15:0]     page_r, page_nxt, e_page;
  logic            phase_r, phase_nxt;
  logic [15:0]     start_page;
  logic [1:0]      n, nres;
  logic [7:0]      c0, c1;
  logic            handled;
  logic            pdig_we;
  logic            commit;
  logic            en;
  imtp_pkg::out_item_t res0, res1;

  assign en         = cfg_i.markup_enable;
  assign start_page = (cfg_i.default_code_page != '0) ? cfg_i.default_code_page
                                                      : cfg_i.global_code_page;

  // Attributes in force: a new string starts from the default registers.
  always_comb begin
    if (mode_r == imtp_pkg::MODE_START) begin
      e_mode  = imtp_pkg::MODE_TEXT;
      e_pend  = 1'b0;
      e_color = cfg_i.default_color;
      e_style = cfg_i.default_style;
      e_page  = start_page;
    end else begin
      e_mode  = mode_r;
      e_pend  = pend_r;
      e_color = color_r;
      e_style = style_r;
      e_page  = page_r;
    end
  end

  // Colour accumulator with the sign-extended nibble at its digit position.
  assign acc_new = acc_r | ({{24{op_i.nib[7]}}, op_i.nib} << {~cnt_r, 2'b00});

  // Tag state machine: next state and the characters this beat emits.
  always_comb begin
    mode_nxt  = e_mode;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    pend_nxt  = e_pend;
    color_nxt = e_color;
    style_nxt = e_style;
    page_nxt  = e_page;
    n         = 2'd0;
    c0        = '0;
    c1        = '0;
    handled   = 1'b0;
    pdig_we   = 1'b0;
    case (e_mode)
      imtp_pkg::MODE_TEXT: begin
        if (e_pend) begin
          pend_nxt = 1'b0;
          n        = 2'd1;
          if (op_i.cls.is_n) begin
            c0      = imtp_pkg::CH_NEWLINE;
            handled = 1'b1;
          end else begin
            c0 = imtp_pkg::CH_BSLASH;
          end
        end
        if (!handled) begin
          if (op_i.cls.is_hash) begin
            mode_nxt = imtp_pkg::MODE_HASH;
          end else if (op_i.cls.is_bslash && !op_i.last) begin
            pend_nxt = 1'b1;
          end else if (n == 2'd0) begin
            c0 = op_i.ch;
            n  = 2'd1;
          end else begin
            c1 = op_i.ch;
            n  = 2'd2;
          end
        end
      end
      imtp_pkg::MODE_HASH: begin
        mode_nxt = imtp_pkg::MODE_TEXT;
        if (op_i.cls.is_c) begin
          mode_nxt = imtp_pkg::MODE_COLOR;
          cnt_nxt  = '0;
          acc_nxt  = '0;
        end else if (op_i.cls.is_l) begin
          mode_nxt = imtp_pkg::MODE_PAGE;
          cnt_nxt  = '0;
        end else if (op_i.cls.is_n) begin
          mode_nxt = imtp_pkg::MODE_NEG;
        end else if (op_i.cls.is_u) begin
          if (en) style_nxt = e_style | imtp_pkg::MASK_UNDERLINE;
        end else if (op_i.cls.is_b) begin
          if (en) style_nxt = e_style | imtp_pkg::MASK_BOLD;
        end else if (op_i.cls.is_s) begin
          if (en) style_nxt = e_style | imtp_pkg::MASK_STRIKE;
        end else if (en) begin
          c0 = imtp_pkg::CH_HASH;
          c1 = op_i.ch;
          n  = 2'd2;
        end
      end
      imtp_pkg::MODE_COLOR: begin
        acc_nxt = acc_new;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == imtp_pkg::COLOR_LAST_DIGIT) begin
          if (en) color_nxt = acc_new;
          mode_nxt = imtp_pkg::MODE_TEXT;
        end
      end
      imtp_pkg::MODE_PAGE: begin
        pdig_we = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == imtp_pkg::PAGE_LAST_DIGIT) begin
          if (en) begin
            page_nxt = imtp_pkg::parse_page({op_i.ch, pdig_r[2], pdig_r[1], pdig_r[0]},
                                            cfg_i.global_code_page);
          end
          mode_nxt = imtp_pkg::MODE_TEXT;
        end
      end
      imtp_pkg::MODE_NEG: begin
        mode_nxt = imtp_pkg::MODE_TEXT;
        if (en) begin
          if (op_i.cls.is_c) begin
            color_nxt = cfg_i.default_color;
          end else if (op_i.cls.is_b) begin
            style_nxt = e_style & ~imtp_pkg::MASK_BOLD;
          end else if (op_i.cls.is_u) begin
            style_nxt = e_style & ~imtp_pkg::MASK_UNDERLINE;
          end else if (op_i.cls.is_s) begin
            style_nxt = e_style & ~imtp_pkg::MASK_STRIKE;
          end else if (op_i.cls.is_l) begin
            page_nxt = start_page;
          end
        end
      end
      default: begin
        mode_nxt = imtp_pkg::MODE_TEXT;
      end
    endcase
    // The last byte closes the string; the next beat starts a new one.
    if (op_i.last) begin
      mode_nxt = imtp_pkg::MODE_START;
      cnt_nxt  = '0;
      pend_nxt = 1'b0;
    end
  end

  // Result beats of this input beat; an empty last beat yields an end marker.
  always_comb begin
    nres = (op_i.last && n == 2'd0) ? 2'd1 : n;
    if (n == 2'd0) begin
      res0          = '0;
      res0.out_last = 1'b1;
    end else begin
      res0.out_char      = c0;
      res0.out_color     = e_color;
      res0.out_style     = e_style;
      res0.out_code_page = e_page;
      res0.has_char      = 1'b1;
      res0.out_last      = op_i.last && (n == 2'd1);
    end
    res1.out_char      = c1;
    res1.out_color     = e_color;
    res1.out_style     = e_style;
    res1.out_code_page = e_page;
    res1.has_char      = 1'b1;
    res1.out_last      = op_i.last;
  end

  // Beat sequencing: a two-result beat pushes both results, one after the other.
  always_comb begin
    commit     = 1'b0;
    res_push_o = 1'b0;
    phase_nxt  = phase_r;
    res_o      = phase_r ? res1 : res0;
    if (!op_empty_i) begin
      if (nres == 2'd0) begin
        commit = 1'b1;
      end else if (!res_full_i) begin
        res_push_o = 1'b1;
        if (nres == 2'd2 && !phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          commit    = 1'b1;
        end
      end
    end
    op_pop_o = commit;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= imtp_pkg::MODE_START;
      cnt_r   <= '0;
      acc_r   <= '0;
      pend_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (commit) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
        acc_r  <= acc_nxt;
        pend_r <= pend_nxt;
      end
    end
  end

  // Attribute and page digit registers; the attributes reload when a string starts.
  always_ff @(posedge clk) begin
    if (commit) begin
      color_r <= color_nxt;
      style_r <= style_nxt;
      page_r  <= page_nxt;
      if (pdig_we) begin
        pdig_r[cnt_r[1:0]] <= op_i.ch;
      end
    end
  end

endmodule

FILE: src/inline_markup_text_parser.sv
// Top level of the inline markup text parser: configuration registers, front end,
// beat queue, back end and result queue. Depends on imtp_pkg and all imtp_ modules.
//
// Usage: bytes of a marked-up string enter as beats on the in_ queue port (push
// while full is low); the last byte of a string carries in_last. Visible
// characters leave on the out_ queue port with their colour, style and code page;
// pop takes the oldest result while empty is low. The final result of a string
// carries out_last, and a string whose last byte shows nothing ends with a marker
// beat whose has_char is low.
// A byte that shows a character is registered in the beat queue, and its result in
// the result queue, before the result appears on the result port.
// Throughput: one byte per cycle while each byte yields at most one result and the
// result queue has room; a byte that yields two results (an unknown tag, or a
// backslash followed by a plain byte) holds the back end until both are pushed,
// as the result queue takes one beat per cycle.
// When the receiver stalls, the result queue fills, the back end waits and the
// beat queue between front and back end fills, after which full rises.
// Reset clears both queues and the parser state and loads the configuration
// registers with their defaults. Configuration is written on the cfg_ port; the user
// must write it only while no string is in flight, which the block does not enforce.

module inline_markup_text_parser #(
  parameter int OP_DEPTH  = 4,
  parameter int RES_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  imtp_pkg::in_item_t                  in_data,
  output logic                                out_empty,
  input  logic                                out_pop,
  output imtp_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [imtp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [imtp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  imtp_pkg::cfg_t      cfg_r, cfg_nxt;
  imtp_pkg::op_t       front_op, back_op;
  imtp_pkg::out_item_t back_res;
  logic                op_empty, op_pop;
  logic                res_full, res_push;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        imtp_pkg::CFG_DEFAULT_COLOR: cfg_nxt.default_color     = cfg_wdata;
        imtp_pkg::CFG_DEFAULT_STYLE: cfg_nxt.default_style     = cfg_wdata[7:0];
        imtp_pkg::CFG_DEFAULT_PAGE:  cfg_nxt.default_code_page = cfg_wdata[15:0];
        imtp_pkg::CFG_GLOBAL_PAGE:   cfg_nxt.global_code_page  = cfg_wdata[15:0];
        imtp_pkg::CFG_MARKUP_EN:     cfg_nxt.markup_enable     = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_color     <= 32'hFFFF_FFFF;
      cfg_r.default_style     <= 8'd0;
      cfg_r.default_code_page <= 16'd1;
      cfg_r.global_code_page  <= 16'd1;
      cfg_r.markup_enable     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: byte classification.
  imtp_front u_front (
    .item_i (in_data),
    .op_o   (front_op)
  );

  // Queue of classified beats between front and back end.
  imtp_fifo #(
    .T     (imtp_pkg::op_t),
    .DEPTH (OP_DEPTH)
  ) u_op_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (front_op),
    .full    (in_full),
    .pop     (op_pop),
    .rd_data (back_op),
    .empty   (op_empty)
  );

  // Back end: tag state machine and result generation.
  imtp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .op_i       (back_op),
    .op_empty_i (op_empty),
    .op_pop_o   (op_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (back_res)
  );

  // Result queue toward the receiver.
  imtp_fifo #(
    .T     (imtp_pkg::out_item_t),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

endmodule

FILE: tb/sv/imtp_markup_checker.sv
// Scoreboard for the inline markup text parser: watches the input, result and configuration ports.
// Depends on imtp_pkg for the beat types, character codes, style masks and register indexes.

`timescale 1ns / 1ps

module imtp_markup_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic                            in_full,
  input  imtp_pkg::in_item_t              in_data,
  input  logic                            out_empty,
  input  logic                            out_pop,
  input  imtp_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [imtp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [imtp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              outstanding
);

  // Character codes used by the atoi-style code page reader.
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;

  // Shadow copy of the configuration registers.
  logic [31:0] cfg_color;
  logic [7:0]  cfg_style;
  logic [15:0] cfg_page;
  logic [15:0] cfg_gpage;
  logic        cfg_markup;

  // Shadow copy of the parser state.
  imtp_pkg::mode_t mode;
  int              digit_cnt;
  logic [31:0]     color_accum;
  logic [31:0]     page_digits;
  logic [31:0]     cur_color;
  logic [7:0]      cur_style;
  logic [15:0]     cur_page;
  logic            pend_bslash;

  // Glyph beats predicted but not yet seen on the result port.
  imtp_pkg::out_item_t expected_glyphs[$];
  int                  produced;
  int                  beats_seen;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch at result beat %0d: %s", $time, beats_seen, what);
    fail_count++;
  endtask

  function automatic logic [15:0] start_page();
    return (cfg_page != 16'd0) ? cfg_page : cfg_gpage;
  endfunction

  // Lax hex digit: bytes 97 to 127 are offset by 87, anything else by 48, then sign-extended.
  function automatic logic [31:0] lax_nibble(input logic [7:0] b);
    logic [7:0] v;
    v = (b >= 8'd97 && b <= 8'd127) ? b - 8'd87 : b + 8'd208;
    return {{24{v[7]}}, v};
  endfunction

  // Four bytes read like atoi: white space, optional sign, decimal digits.
  function automatic logic [15:0] decode_page(input logic [31:0] digits);
    logic [7:0]  ch [4];
    int          pos;
    logic [31:0] val;
    logic        neg;
    for (int i = 0; i < 4; i++) begin
      ch[i] = digits[8*i +: 8];
    end
    pos = 0;
    val = '0;
    neg = 1'b0;
    while (pos < 4 && (ch[pos] == imtp_pkg::CH_SPACE ||
                       (ch[pos] >= CH_TAB && ch[pos] <= CH_CR))) begin
      pos++;
    end
    if (pos < 4 && (ch[pos] == imtp_pkg::CH_PLUS || ch[pos] == imtp_pkg::CH_MINUS)) begin
      neg = (ch[pos] == imtp_pkg::CH_MINUS);
      pos++;
    end
    while (pos < 4 && ch[pos] >= CH_DIGIT_0 && ch[pos] <= CH_DIGIT_9) begin
      val = val * 32'd10 + {24'd0, ch[pos] - CH_DIGIT_0};
      pos++;
    end
    if (neg) begin
      val = 32'd0 - val;
    end
    return (val == 32'd0) ? cfg_gpage : val[15:0];
  endfunction

  task automatic reload_attributes();
    cur_color = cfg_color;
    cur_style = cfg_style;
    cur_page  = start_page();
  endtask

  task automatic emit_glyph(input logic [7:0] ch);
    imtp_pkg::out_item_t beat;
    beat.out_char      = ch;
    beat.out_color     = cur_color;
    beat.out_style     = cur_style;
    beat.out_code_page = cur_page;
    beat.has_char      = 1'b1;
    beat.out_last      = 1'b0;
    expected_glyphs.push_back(beat);
    produced++;
  endtask

  // Advance the shadow parser by one byte and queue the glyphs it shows.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic                en;
    logic                escaped;
    imtp_pkg::out_item_t tail;
    en       = cfg_markup;
    escaped  = 1'b0;
    produced = 0;
    if (mode == imtp_pkg::MODE_START) begin
      reload_attributes();
      pend_bslash = 1'b0;
      mode = imtp_pkg::MODE_TEXT;
    end
    case (mode)
      imtp_pkg::MODE_TEXT: begin
        // A held backslash either becomes a newline or is shown as itself.
        if (pend_bslash) begin
          pend_bslash = 1'b0;
          if (b == imtp_pkg::CH_N) begin
            emit_glyph(imtp_pkg::CH_NEWLINE);
            escaped = 1'b1;
          end else begin
            emit_glyph(imtp_pkg::CH_BSLASH);
          end
        end
        if (!escaped) begin
          if (b == imtp_pkg::CH_HASH) begin
            mode = imtp_pkg::MODE_HASH;
          end else if (b == imtp_pkg::CH_BSLASH && !last) begin
            pend_bslash = 1'b1;
          end else begin
            emit_glyph(b);
          end
        end
      end
      imtp_pkg::MODE_HASH: begin
        mode = imtp_pkg::MODE_TEXT;
        if (b == imtp_pkg::CH_C) begin
          mode = imtp_pkg::MODE_COLOR;
          digit_cnt = 0;
          color_accum = '0;
        end else if (b == imtp_pkg::CH_L) begin
          mode = imtp_pkg::MODE_PAGE;
          digit_cnt = 0;
          page_digits = '0;
        end else if (b == imtp_pkg::CH_N) begin
          mode = imtp_pkg::MODE_NEG;
        end else if (b == imtp_pkg::CH_U) begin
          if (en) cur_style |= imtp_pkg::MASK_UNDERLINE;
        end else if (b == imtp_pkg::CH_B) begin
          if (en) cur_style |= imtp_pkg::MASK_BOLD;
        end else if (b == imtp_pkg::CH_S) begin
          if (en) cur_style |= imtp_pkg::MASK_STRIKE;
        end else if (en) begin
          emit_glyph(imtp_pkg::CH_HASH);
          emit_glyph(b);
        end
      end
      imtp_pkg::MODE_COLOR: begin
        color_accum |= lax_nibble(b) << (4 * (7 - digit_cnt));
        digit_cnt++;
        if (digit_cnt >= 8) begin
          if (en) cur_color = color_accum;
          mode = imtp_pkg::MODE_TEXT;
        end
      end
      imtp_pkg::MODE_PAGE: begin
        page_digits |= {24'd0, b} << (8 * digit_cnt);
        digit_cnt++;
        if (digit_cnt >= 4) begin
          if (en) cur_page = decode_page(page_digits);
          mode = imtp_pkg::MODE_TEXT;
        end
      end
      default: begin
        // Restore or clear one attribute; any other letter is swallowed.
        if (en) begin
          if (b == imtp_pkg::CH_C) cur_color = cfg_color;
          else if (b == imtp_pkg::CH_B) cur_style &= ~imtp_pkg::MASK_BOLD;
          else if (b == imtp_pkg::CH_U) cur_style &= ~imtp_pkg::MASK_UNDERLINE;
          else if (b == imtp_pkg::CH_S) cur_style &= ~imtp_pkg::MASK_STRIKE;
          else if (b == imtp_pkg::CH_L) cur_page = start_page();
        end
        mode = imtp_pkg::MODE_TEXT;
      end
    endcase

    // The closing byte tags its last glyph, or stands alone as an empty end marker.
    if (last) begin
      if (produced == 0) begin
        tail = '0;
      end else begin
        tail = expected_glyphs.pop_back();
      end
      tail.out_last = 1'b1;
      expected_glyphs.push_back(tail);
      mode = imtp_pkg::MODE_START;
      digit_cnt = 0;
      pend_bslash = 1'b0;
      reload_attributes();
    end
  endtask

  task automatic check_beat(input imtp_pkg::out_item_t got);
    imtp_pkg::out_item_t want;
    if (expected_glyphs.size() == 0) begin
      report_mismatch($sformatf("unexpected beat %h", got));
    end else begin
      want = expected_glyphs.pop_front();
      if (got.out_char !== want.out_char)
        report_mismatch($sformatf("out_char %h, expected %h", got.out_char, want.out_char));
      if (got.out_color !== want.out_color)
        report_mismatch($sformatf("out_color %h, expected %h", got.out_color, want.out_color));
      if (got.out_style !== want.out_style)
        report_mismatch($sformatf("out_style %h, expected %h", got.out_style, want.out_style));
      if (got.out_code_page !== want.out_code_page)
        report_mismatch($sformatf("out_code_page %h, expected %h",
                                  got.out_code_page, want.out_code_page));
      if (got.has_char !== want.has_char)
        report_mismatch($sformatf("has_char %b, expected %b", got.has_char, want.has_char));
      if (got.out_last !== want.out_last)
        report_mismatch($sformatf("out_last %b, expected %b", got.out_last, want.out_last));
    end
    beats_seen++;
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
    beats_seen  = 0;
  end

  // Everything is sampled at the rising edge; results are checked before new bytes are parsed.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_color   = 32'hFFFF_FFFF;
      cfg_style   = 8'd0;
      cfg_page    = 16'd1;
      cfg_gpage   = 16'd1;
      cfg_markup  = 1'b1;
      mode        = imtp_pkg::MODE_START;
      digit_cnt   = 0;
      color_accum = '0;
      page_digits = '0;
      pend_bslash = 1'b0;
      reload_attributes();
      expected_glyphs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          imtp_pkg::CFG_DEFAULT_COLOR: cfg_color  = cfg_wdata[31:0];
          imtp_pkg::CFG_DEFAULT_STYLE: cfg_style  = cfg_wdata[7:0];
          imtp_pkg::CFG_DEFAULT_PAGE:  cfg_page   = cfg_wdata[15:0];
          imtp_pkg::CFG_GLOBAL_PAGE:   cfg_gpage  = cfg_wdata[15:0];
          imtp_pkg::CFG_MARKUP_EN:     cfg_markup = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        check_beat(out_data);
      end
      if (in_push && !in_full) begin
        parse_byte(in_data.in_char, in_data.in_last);
      end
    end
    outstanding = expected_glyphs.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the inline markup text parser testbench: clock, reset, configuration and byte stimulus.
// Depends on imtp_pkg, the parser RTL and imtp_markup_checker, which predicts and compares.

`timescale 1ns / 1ps

module testbench;

  localparam string HEX_DIGITS  = "0123456789abcdef";
  localparam string DEC_DIGITS  = "0123456789";
  localparam string PAGE_CHARS  = " \t+-0123456789";
  localparam string STYLE_TAGS  = "ubs";
  localparam string RESET_TAGS  = "cbusl";
  localparam int    PHASE_COUNT = 8;
  localparam int    PHASE_ITEMS = 250;

  logic                            clk;
  logic                            rst_n;
  logic                            in_push;
  logic                            in_full;
  imtp_pkg::in_item_t              in_data;
  logic                            out_empty;
  logic                            out_pop;
  imtp_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [imtp_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [imtp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                              fail_count;
  int                              outstanding;

  bit                              steady;
  int                              bytes_sent;
  logic [7:0]                      text_q[$];

  inline_markup_text_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  imtp_markup_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #800000;
    $display("inline_markup_text_parser regression: fail");
    $finish;
  end

  // Receiver: pops at random, except during the steady stretch.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop = steady || ($urandom_range(99) >= 27);
    end
  end

  // One input beat: optional idle cycles, then hold push until the block takes it.
  task automatic send_byte(input logic [7:0] ch, input logic last);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 27) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_data.in_char = ch;
    in_data.in_last = last;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    bytes_sent += text_q.size();
  endtask

  task automatic write_reg(input logic [imtp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
  endtask

  // Registers change only once the parser has drained every string.
  task automatic program_settings(input logic [31:0] color, input logic [7:0] style,
                                  input logic [15:0] page, input logic [15:0] gpage,
                                  input logic en);
    @(negedge clk);
    in_push = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    write_reg(imtp_pkg::CFG_DEFAULT_COLOR, color);
    write_reg(imtp_pkg::CFG_DEFAULT_STYLE, {24'd0, style});
    write_reg(imtp_pkg::CFG_DEFAULT_PAGE, {16'd0, page});
    write_reg(imtp_pkg::CFG_GLOBAL_PAGE, {16'd0, gpage});
    write_reg(imtp_pkg::CFG_MARKUP_EN, {31'd0, en});
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  // Random string built from plain characters, escapes and tags with random arguments.
  task automatic build_string();
    int kind;
    int keep;
    text_q.delete();
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(6, 1)) text_q.push_back(any_byte());
      return;
    end
    repeat ($urandom_range(8, 1)) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        text_q.push_back(8'($urandom_range(126, 32)));
      end else if (kind < 38) begin
        text_q.push_back(any_byte());
      end else if (kind < 50) begin
        text_q.push_back(imtp_pkg::CH_HASH);
        text_q.push_back(imtp_pkg::CH_C);
        repeat (8) begin
          if ($urandom_range(99) < 60) text_q.push_back(HEX_DIGITS[$urandom_range(15)]);
          else text_q.push_back(any_byte());
        end
      end else if (kind < 60) begin
        text_q.push_back(imtp_pkg::CH_HASH);
        text_q.push_back(imtp_pkg::CH_L);
        repeat (4) begin
          keep = $urandom_range(99);
          if (keep < 50) text_q.push_back(DEC_DIGITS[$urandom_range(9)]);
          else if (keep < 85) text_q.push_back(PAGE_CHARS[$urandom_range(13)]);
          else text_q.push_back(any_byte());
        end
      end else if (kind < 72) begin
        text_q.push_back(imtp_pkg::CH_HASH);
        text_q.push_back(STYLE_TAGS[$urandom_range(2)]);
      end else if (kind < 82) begin
        text_q.push_back(imtp_pkg::CH_HASH);
        text_q.push_back(imtp_pkg::CH_N);
        if ($urandom_range(99) < 80) text_q.push_back(RESET_TAGS[$urandom_range(4)]);
        else text_q.push_back(any_byte());
      end else if (kind < 88) begin
        text_q.push_back(imtp_pkg::CH_HASH);
        text_q.push_back(any_byte());
      end else if (kind < 94) begin
        text_q.push_back(imtp_pkg::CH_BSLASH);
        text_q.push_back(imtp_pkg::CH_N);
      end else begin
        text_q.push_back(imtp_pkg::CH_BSLASH);
        text_q.push_back(any_byte());
      end
    end
    // Sometimes the string is cut short, possibly in the middle of a tag.
    if ($urandom_range(99) < 10) begin
      keep = $urandom_range(text_q.size(), 1);
      while (text_q.size() > keep) void'(text_q.pop_back());
    end
  endtask

  initial begin
    int phase_end;
    int wait_cycles;
    logic en;
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    steady     = 1'b0;
    bytes_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed strings: lax colour digits, negative page, escapes, unknown tags, cut-off tag.
    program_settings(32'h12AB_34CD, 8'h01, 16'd1200, 16'd437, 1'b1);
    text_q = '{imtp_pkg::CH_HASH, imtp_pkg::CH_C, "z", "0", "a", 8'h00, "~", "F", 8'hFF,
               "9", "A"};
    send_text();
    text_q = '{imtp_pkg::CH_HASH, imtp_pkg::CH_L, "-", "0", "0", "1", imtp_pkg::CH_HASH,
               imtp_pkg::CH_S, imtp_pkg::CH_BSLASH, "q"};
    send_text();
    text_q = '{imtp_pkg::CH_HASH, imtp_pkg::CH_N, "z", imtp_pkg::CH_HASH, "x",
               imtp_pkg::CH_BSLASH, imtp_pkg::CH_N, imtp_pkg::CH_HASH, imtp_pkg::CH_L};
    send_text();

    // Random phases, each under its own register settings.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: program_settings(32'h0000_0000, 8'h00, 16'd1, 16'd1, 1'b1);
        1: program_settings(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        2: program_settings($urandom, 8'($urandom_range(255)), 16'($urandom_range(65535, 1)),
                            16'($urandom_range(65535, 1)), 1'b0);
        default: begin
          en = ($urandom_range(99) >= 20);
          program_settings($urandom, 8'($urandom_range(255)), 16'($urandom_range(65535, 1)),
                           16'($urandom_range(65535, 1)), en);
        end
      endcase
      steady = (phase == 4);
      phase_end = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < phase_end) begin
        build_string();
        send_text();
      end
    end

    // Drain, then give the block time to show any stray beat.
    @(negedge clk);
    in_push = 1'b0;
    steady  = 1'b0;
    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (20) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("inline_markup_text_parser regression: pass");
    end else begin
      $display("inline_markup_text_parser regression: fail");
    end
    $finish;
  end

endmodule

FILE: inline_markup_text_parser.f
src/imtp_pkg.sv
src/imtp_fifo.sv
src/imtp_front.sv
src/imtp_back.sv
src/inline_markup_text_parser.sv
tb/sv/imtp_markup_checker.sv
tb/sv/testbench.sv
